/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes of the source text tokenizer: character classes,
// token kinds, the queue entry and the token beat.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH          = 4;

    // character classes, set by the front, used by the back
    localparam logic [2:0] CLS_SPACE   = 3'd0;
    localparam logic [2:0] CLS_NEWLINE = 3'd1;
    localparam logic [2:0] CLS_SINGLE  = 3'd2;  // one-char token, kind in entry
    localparam logic [2:0] CLS_HASH    = 3'd3;
    localparam logic [2:0] CLS_LETTER  = 3'd4;
    localparam logic [2:0] CLS_UNDER   = 3'd5;
    localparam logic [2:0] CLS_DIGIT   = 3'd6;
    localparam logic [2:0] CLS_POINT   = 3'd7;

    // token kinds
    localparam logic [3:0] KIND_END      = 4'd0;
    localparam logic [3:0] KIND_NEWLINE  = 4'd1;
    localparam logic [3:0] KIND_LPAREN   = 4'd2;
    localparam logic [3:0] KIND_RPAREN   = 4'd3;
    localparam logic [3:0] KIND_PLUS     = 4'd4;
    localparam logic [3:0] KIND_MINUS    = 4'd5;
    localparam logic [3:0] KIND_STAR     = 4'd6;
    localparam logic [3:0] KIND_SLASH    = 4'd7;
    localparam logic [3:0] KIND_PERCENT  = 4'd8;
    localparam logic [3:0] KIND_SYMBOL   = 4'd9;
    localparam logic [3:0] KIND_FUNCTION = 4'd10;
    localparam logic [3:0] KIND_LET      = 4'd11;
    localparam logic [3:0] KIND_INTEGER  = 4'd12;
    localparam logic [3:0] KIND_FLOAT    = 4'd13;
    localparam logic [3:0] KIND_ILLEGAL  = 4'd14;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
        logic [2:0] cls;
        logic [3:0] kind;
    } entry_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start_offset;
        logic [15:0] length;
        logic [15:0] column;
        logic [15:0] line;
        logic        last_of_run;
    } tok_t;

endpackage

/* rtl/stt_front.sv */
// ----------------------------------------------------------------------------
// stt_front
// Input side: takes character beats and sorts each byte into a class.
// ----------------------------------------------------------------------------
module stt_front
(
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           func,
    input  logic [7:0]     ch,
    output logic           push_valid,
    input  logic           push_ready,
    output stt_pkg::entry_t push_entry
);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    logic [7:0] lower;
    logic [2:0] cls;
    logic [3:0] kind;

    assign lower = ch | 8'h20;

    always_comb
    begin
        cls  = stt_pkg::CLS_SINGLE;
        kind = stt_pkg::KIND_ILLEGAL;
        case (ch)
            8'h20, 8'h09, 8'h0D: cls = stt_pkg::CLS_SPACE;
            CH_NEWLINE:          cls = stt_pkg::CLS_NEWLINE;
            CH_HASH:             cls = stt_pkg::CLS_HASH;
            CH_POINT:            cls = stt_pkg::CLS_POINT;
            CH_UNDER:            cls = stt_pkg::CLS_UNDER;
            8'h28:               kind = stt_pkg::KIND_LPAREN;
            8'h29:               kind = stt_pkg::KIND_RPAREN;
            8'h2B:               kind = stt_pkg::KIND_PLUS;
            8'h2D:               kind = stt_pkg::KIND_MINUS;
            8'h2A:               kind = stt_pkg::KIND_STAR;
            8'h2F:               kind = stt_pkg::KIND_SLASH;
            8'h25:               kind = stt_pkg::KIND_PERCENT;
            default:
            begin
                if (ch inside {[8'h30:8'h39]})
                    cls = stt_pkg::CLS_DIGIT;
                else if (lower inside {[8'h61:8'h7A]})
                    cls = stt_pkg::CLS_LETTER;
            end
        endcase
    end

    assign in_ready        = push_ready;
    assign push_valid      = in_valid;
    assign push_entry.func = func;
    assign push_entry.ch   = ch;
    assign push_entry.cls  = cls;
    assign push_entry.kind = kind;

endmodule

/* rtl/stt_queue.sv */
// ----------------------------------------------------------------------------
// stt_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module stt_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  stt_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output stt_pkg::entry_t pop_entry
);

    localparam int DEPTH = stt_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    stt_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* rtl/stt_back.sv */
// ----------------------------------------------------------------------------
// stt_back
// Scanner proper: keeps the scan mode and counters, builds up to two
// tokens per character and hands them out through an output register
// with a one-token hold stage.
// ----------------------------------------------------------------------------
module stt_back
#(
    parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  stt_pkg::entry_t pop_entry,
    output logic            out_valid,
    input  logic            out_ready,
    output stt_pkg::tok_t   out_tok
);

    localparam int CB = COUNTER_BITS;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_IDENT   = 2'd1;
    localparam logic [1:0] MODE_NUMBER  = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == {CB{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] to_out(input logic [CB-1:0] v);
        logic [CB+15:0] w;
        w = {16'b0, v};
        return w[15:0];
    endfunction

    function automatic logic [7:0] kw_function_char(input logic [2:0] i);
        case (i)
            3'd0:    return 8'h66;
            3'd1:    return 8'h75;
            3'd2:    return 8'h6E;
            3'd3:    return 8'h63;
            3'd4:    return 8'h74;
            3'd5:    return 8'h69;
            3'd6:    return 8'h6F;
            default: return 8'h6E;
        endcase
    endfunction

    function automatic logic [7:0] kw_let_char(input logic [1:0] i);
        case (i)
            2'd0:    return 8'h6C;
            2'd1:    return 8'h65;
            2'd2:    return 8'h74;
            default: return 8'h00;
        endcase
    endfunction

    logic [1:0]    mode_reg, mode_next;
    logic          point_reg, point_next;
    logic [1:0]    cand_reg, cand_next;
    logic [CB-1:0] start_reg, start_next;
    logic [CB-1:0] scol_reg, scol_next;
    logic [CB-1:0] len_reg, len_next;
    logic [CB-1:0] off_reg, off_next;
    logic [CB-1:0] col_reg, col_next;
    logic [CB-1:0] line_reg, line_next;

    logic          out_valid_reg, hold_valid_reg;
    stt_pkg::tok_t out_tok_reg, hold_tok_reg;

    logic          pop;
    logic          pend, sgl, consumed, adv;
    logic [3:0]    sgl_kind, pend_kind;
    logic          f_ok, l_ok, ident_cont, num_more;
    stt_pkg::tok_t pend_tok, sgl_tok, first_tok, second_tok;
    stt_pkg::entry_t e;

    assign e         = pop_entry;
    assign pop_ready = !hold_valid_reg && (!out_valid_reg || out_ready);
    assign pop       = pop_valid && pop_ready;

    // keyword tracking at the current token position
    assign f_ok = (len_reg < CB'(8)) && (kw_function_char(len_reg[2:0]) == e.ch);
    assign l_ok = (len_reg < CB'(3)) && (kw_let_char(len_reg[1:0]) == e.ch);

    assign ident_cont = (e.cls == stt_pkg::CLS_LETTER) || (e.cls == stt_pkg::CLS_DIGIT) ||
                        (e.cls == stt_pkg::CLS_UNDER);
    assign num_more   = (e.cls == stt_pkg::CLS_DIGIT) || (e.cls == stt_pkg::CLS_UNDER) ||
                        ((e.cls == stt_pkg::CLS_POINT) && !point_reg);

    always_comb
    begin
        if (mode_reg == MODE_IDENT)
        begin
            if (cand_reg[0] && (len_reg == CB'(8)))
                pend_kind = stt_pkg::KIND_FUNCTION;
            else if (cand_reg[1] && (len_reg == CB'(3)))
                pend_kind = stt_pkg::KIND_LET;
            else
                pend_kind = stt_pkg::KIND_SYMBOL;
        end
        else
            pend_kind = point_reg ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INTEGER;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        point_next = point_reg;
        cand_next  = cand_reg;
        start_next = start_reg;
        scol_next  = scol_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        pend       = 1'b0;
        sgl        = 1'b0;
        sgl_kind   = stt_pkg::KIND_END;
        consumed   = 1'b0;
        adv        = 1'b0;

        if (e.func)
        begin
            pend      = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
            mode_next = MODE_IDLE;
            sgl       = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (ident_cont)
                    begin
                        cand_next = cand_reg & {l_ok, f_ok};
                        len_next  = sat_inc(len_reg);
                        adv       = 1'b1;
                        consumed  = 1'b1;
                    end
                    else
                    begin
                        pend      = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (num_more)
                    begin
                        if (e.cls == stt_pkg::CLS_POINT)
                            point_next = 1'b1;
                        len_next = sat_inc(len_reg);
                        adv      = 1'b1;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        pend      = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COMMENT:
                begin
                    if (e.cls != stt_pkg::CLS_NEWLINE)
                    begin
                        adv      = 1'b1;
                        consumed = 1'b1;
                    end
                    else
                        mode_next = MODE_IDLE;
                end
                default: ;
            endcase

            if (!consumed)
            begin
                case (e.cls)
                    stt_pkg::CLS_SPACE: adv = 1'b1;
                    stt_pkg::CLS_NEWLINE:
                    begin
                        sgl       = 1'b1;
                        sgl_kind  = stt_pkg::KIND_NEWLINE;
                        off_next  = sat_inc(off_reg);
                        line_next = sat_inc(line_reg);
                        col_next  = CB'(1);
                    end
                    stt_pkg::CLS_HASH:
                    begin
                        mode_next = MODE_COMMENT;
                        adv       = 1'b1;
                    end
                    stt_pkg::CLS_LETTER, stt_pkg::CLS_UNDER:
                    begin
                        mode_next  = MODE_IDENT;
                        cand_next  = {e.ch == kw_let_char(2'd0), e.ch == kw_function_char(3'd0)};
                        start_next = off_reg;
                        scol_next  = col_reg;
                        len_next   = CB'(1);
                        adv        = 1'b1;
                    end
                    stt_pkg::CLS_DIGIT:
                    begin
                        mode_next  = MODE_NUMBER;
                        point_next = 1'b0;
                        start_next = off_reg;
                        scol_next  = col_reg;
                        len_next   = CB'(1);
                        adv        = 1'b1;
                    end
                    stt_pkg::CLS_POINT:
                    begin
                        sgl      = 1'b1;
                        sgl_kind = stt_pkg::KIND_ILLEGAL;
                        adv      = 1'b1;
                    end
                    default:
                    begin
                        sgl      = 1'b1;
                        sgl_kind = e.kind;
                        adv      = 1'b1;
                    end
                endcase
            end
        end

        if (adv)
        begin
            off_next = sat_inc(off_reg);
            col_next = sat_inc(col_reg);
        end
    end

    always_comb
    begin
        pend_tok.kind         = pend_kind;
        pend_tok.start_offset = to_out(start_reg);
        pend_tok.length       = to_out(len_reg);
        pend_tok.column       = to_out(scol_reg);
        pend_tok.line         = to_out(line_reg);
        pend_tok.last_of_run  = !sgl;

        sgl_tok.kind          = sgl_kind;
        sgl_tok.start_offset  = to_out(off_reg);
        sgl_tok.length        = 16'd1;
        sgl_tok.column        = to_out(col_reg);
        sgl_tok.line          = to_out(line_reg);
        sgl_tok.last_of_run   = 1'b1;

        first_tok  = pend ? pend_tok : sgl_tok;
        second_tok = sgl_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            point_reg      <= 1'b0;
            cand_reg       <= 2'b11;
            start_reg      <= '0;
            scol_reg       <= CB'(1);
            len_reg        <= '0;
            off_reg        <= '0;
            col_reg        <= CB'(1);
            line_reg       <= CB'(1);
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                point_reg <= point_next;
                cand_reg  <= cand_next;
                start_reg <= start_next;
                scol_reg  <= scol_next;
                len_reg   <= len_next;
                off_reg   <= off_next;
                col_reg   <= col_next;
                line_reg  <= line_next;
            end

            if (hold_valid_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (pop && (pend || sgl))
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= pend && sgl;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_valid_reg && (!out_valid_reg || out_ready))
            out_tok_reg <= hold_tok_reg;
        else if (pop && (pend || sgl))
        begin
            out_tok_reg  <= first_tok;
            hold_tok_reg <= second_tok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold stage full while output register empty");

    a_hold_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> hold_tok_reg.last_of_run)
        else $error("held token not last of its run");

    a_first_has_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_tok_reg.last_of_run) |-> hold_valid_reg)
        else $error("non-final token without a follower");

    a_end_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_tok_reg.kind == stt_pkg::KIND_END)) |->
        (out_tok_reg.length == 16'd1) && out_tok_reg.last_of_run)
        else $error("malformed end token");

endmodule

/* rtl/source_text_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming lexical scanner: one character beat in, token beats out.
// ----------------------------------------------------------------------------
// Each input beat carries one character (func = 0) or an end-of-text mark
// (func = 1). Tokens come out as soon as they are known: a pending
// identifier or number goes out when the character that ends it arrives,
// ahead of any token of that character, so one input beat yields zero, one
// or two token beats; last_of_run marks the final one of each beat. The
// scanner takes one character per cycle unless the output stalls; a beat
// with two tokens parks the second in the hold stage, and no character is
// taken until the hold stage has drained. A four-entry queue of
// classified characters between the input classifier and the scanner lets
// the input keep flowing while the output side stalls. Offset, column,
// line and token length saturate at 2^COUNTER_BITS - 1; the output fields
// carry their low 16 bits. Nothing is cleared after reset beyond the
// flip-flops themselves, so the block takes beats from the first cycle.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top
#(
    parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [15:0] start_offset,
    output logic [15:0] length,
    output logic [15:0] column,
    output logic [15:0] line,
    output logic        last_of_run
);

    logic            push_valid, push_ready;
    stt_pkg::entry_t push_entry;
    logic            pop_valid, pop_ready;
    stt_pkg::entry_t pop_entry;
    stt_pkg::tok_t   tok;

    // classify bytes as they arrive
    stt_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .ch         (ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decouples input from scanner/output stalls
    stt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // scan state, token build and output beat
    stt_back #(.COUNTER_BITS(COUNTER_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (tok)
    );

    assign kind         = tok.kind;
    assign start_offset = tok.start_offset;
    assign length       = tok.length;
    assign column       = tok.column;
    assign line         = tok.line;
    assign last_of_run  = tok.last_of_run;

endmodule
